@@ hw/rtl/dphk_pkg.sv @@
// Shared types, constants and state-map helpers for the double pair Hilbert key.
package dphk_pkg;

  localparam int CURVE_ORDER = 32;
  localparam int RAW_W       = 64;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = 2 * CURVE_ORDER;
  localparam int SCAN_STAGES = $clog2(CURVE_ORDER);

  typedef logic [RAW_W-1:0]       raw_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [CURVE_ORDER-1:0] coord_t;
  typedef logic [IDX_W-1:0]       idx_t;

  // Orientation state: [1] swap, [0] invert.
  typedef logic [1:0] st_t;
  // Map from orientation state to next state, entry s at bits [2s+1:2s].
  typedef logic [7:0] smap_t;
  // Orientation entering each level, level 0 being the top bit.
  typedef logic [CURVE_ORDER-1:0][1:0] st_vec_t;

  localparam st_t ST_START = 2'b00;

  // State map of one level, given that level's raw x and y bits.
  function automatic smap_t level_map(input logic xb, input logic yb);
    smap_t m;
    st_t   s;
    logic  rx;
    logic  ry;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      s  = st_t'(i);
      rx = (s[1] ? yb : xb) ^ s[0];
      ry = (s[1] ? xb : yb) ^ s[0];
      m[2*i +: 2] = ry ? s : {~s[1], s[0] ^ rx};
    end
    return m;
  endfunction

  // Map that applies f first and then g.
  function automatic smap_t map_compose(input smap_t f, input smap_t g);
    smap_t r;
    st_t   mid;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      mid = f[2*i +: 2];
      r[2*i +: 2] = g[2*mid +: 2];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/dphk_quant.sv @@
// Order-preserving mapping of a double bit pattern to an axis coordinate.
module dphk_quant (
  input  dphk_pkg::raw_t   bits,
  output dphk_pkg::coord_t coord
);
  import dphk_pkg::*;

  raw_t mapped;

  // Negative: invert all; positive: flip the sign bit.
  assign mapped = bits[RAW_W-1] ? ~bits : {~bits[RAW_W-1], bits[RAW_W-2:0]};
  assign coord  = mapped[RAW_W-1 -: CURVE_ORDER];

endmodule

@@ hw/rtl/dphk_scan.sv @@
// Parallel prefix over per-level state maps: orientation entering each level.
module dphk_scan (
  input  dphk_pkg::coord_t  qx,
  input  dphk_pkg::coord_t  qy,
  output dphk_pkg::st_vec_t st_in
);
  import dphk_pkg::*;

  smap_t lvl [0:SCAN_STAGES][CURVE_ORDER];

  genvar k, j;
  generate
    for (k = 0; k < CURVE_ORDER; k++) begin : g_leaf
      assign lvl[0][k] = level_map(qx[CURVE_ORDER-1-k], qy[CURVE_ORDER-1-k]);
    end
    for (j = 0; j < SCAN_STAGES; j++) begin : g_stage
      for (k = 0; k < CURVE_ORDER; k++) begin : g_node
        if (k >= (1 << j)) begin : g_join
          assign lvl[j+1][k] = map_compose(lvl[j][k-(1<<j)], lvl[j][k]);
        end else begin : g_pass
          assign lvl[j+1][k] = lvl[j][k];
        end
      end
    end
    // Level k starts from the state left by levels 0..k-1.
    for (k = 0; k < CURVE_ORDER; k++) begin : g_out
      if (k == 0) begin : g_first
        assign st_in[k] = ST_START;
      end else begin : g_rest
        assign st_in[k] = lvl[SCAN_STAGES][k-1][2*ST_START +: 2];
      end
    end
  endgenerate

endmodule

@@ hw/rtl/dphk_digits.sv @@
// Hilbert quadrant digit of each level from its bits and entering orientation.
module dphk_digits (
  input  dphk_pkg::coord_t  qx,
  input  dphk_pkg::coord_t  qy,
  input  dphk_pkg::st_vec_t st_in,
  output dphk_pkg::idx_t    index
);
  import dphk_pkg::*;

  genvar k;
  generate
    for (k = 0; k < CURVE_ORDER; k++) begin : g_lvl
      logic rx;
      logic ry;
      assign rx = (st_in[k][1] ? qy[CURVE_ORDER-1-k] : qx[CURVE_ORDER-1-k]) ^ st_in[k][0];
      assign ry = (st_in[k][1] ? qx[CURVE_ORDER-1-k] : qy[CURVE_ORDER-1-k]) ^ st_in[k][0];
      // (3*rx) xor ry as two bits, placed at weight s*s.
      assign index[2*(CURVE_ORDER-1-k) +: 2] = {rx, rx ^ ry};
    end
  endgenerate

endmodule

@@ hw/rtl/double_pair_hilbert_key.sv @@
// Top level: Hilbert key of a point given as two double bit patterns.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | in_valid, in_ready, in_x_bits,      | in
//           | in_y_bits                           |
//   result  | out_valid, out_ready,               | out
//           | out_hilbert_index                   |
//
// The input transfer loads the input register; quantize, orientation prefix scan
// and digit logic then feed the result register. One item is taken every cycle
// while the result side does not stall; the five-stage prefix scan over
// the per-level state maps sets the combinational depth.
// Reset (rst_n low, synchronous) clears both valid flags; payload is not reset.
// A stall at the result side holds the result register, and the input register
// holds too once it is full, so in_ready drops only when both stages are full.
module double_pair_hilbert_key (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dphk_pkg::raw_t in_x_bits,
  input  dphk_pkg::raw_t in_y_bits,
  output logic           out_valid,
  input  logic           out_ready,
  output dphk_pkg::key_t out_hilbert_index
);
  import dphk_pkg::*;

  // Input stage
  logic    in_vld_r;
  logic    in_vld_nxt;
  raw_t    x_r;
  raw_t    y_r;
  // Result stage
  logic    out_vld_r;
  logic    out_vld_nxt;
  key_t    idx_r;

  logic    adv_out;
  logic    adv_in;
  coord_t  qx;
  coord_t  qy;
  st_vec_t st_in;
  idx_t    index;

  // Result register loads when empty or when its transfer completes.
  assign adv_out = !out_vld_r || out_ready;
  // Input register loads when empty or when its item moves on.
  assign adv_in  = !in_vld_r || adv_out;
  assign in_ready = adv_in;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (adv_in) begin
      in_vld_nxt = in_valid;
    end
    if (adv_out) begin
      out_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture payload on input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && adv_in) begin
      x_r <= in_x_bits;
      y_r <= in_y_bits;
    end
  end

  // Map both coordinates to order-preserving unsigned values.
  dphk_quant u_quant_x (.bits(x_r), .coord(qx));
  dphk_quant u_quant_y (.bits(y_r), .coord(qy));

  // Orientation entering each level via a prefix scan of state maps.
  dphk_scan u_scan (.qx(qx), .qy(qy), .st_in(st_in));

  // Per-level quadrant digits form the index.
  dphk_digits u_digits (.qx(qx), .qy(qy), .st_in(st_in), .index(index));

  // Advance the result register; hold it while the consumer stalls.
  always_ff @(posedge clk) begin
    if (in_vld_r && adv_out) begin
      idx_r <= KEY_W'(index);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_hilbert_index = idx_r;

endmodule

@@ test/double_pair_hilbert_key_tb.sv @@
// Testbench for double_pair_hilbert_key: streamed point pairs checked against a predictor.
module testbench;
  import dphk_pkg::*;

  // One input transfer: the raw bit patterns of both coordinates.
  typedef struct packed {
    raw_t x;
    raw_t y;
  } point_t;

  // Notable double bit patterns.
  localparam raw_t POS_ZERO   = 64'h0000_0000_0000_0000;
  localparam raw_t NEG_ZERO   = 64'h8000_0000_0000_0000;
  localparam raw_t POS_INF    = 64'h7FF0_0000_0000_0000;
  localparam raw_t NEG_INF    = 64'hFFF0_0000_0000_0000;
  localparam raw_t POS_QNAN   = 64'h7FF8_0000_0000_0000;
  localparam raw_t NEG_QNAN   = 64'hFFF8_0000_0000_0001;
  localparam raw_t MAX_NORMAL = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam raw_t MIN_NORMAL = 64'h0010_0000_0000_0000;
  localparam raw_t MIN_DENORM = 64'h0000_0000_0000_0001;
  localparam raw_t PLUS_ONE   = 64'h3FF0_0000_0000_0000;
  localparam raw_t MINUS_ONE  = 64'hBFF0_0000_0000_0000;
  localparam raw_t ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam raw_t POS_NAN_HI = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam raw_t NEG_DENORM = 64'h8000_0000_0000_0001;
  localparam raw_t STRIPE_A   = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam raw_t STRIPE_5   = 64'h5555_5555_5555_5555;

  localparam int TOTAL_POINTS = 2000;
  localparam int NUM_SPECIALS = 16;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  raw_t in_x_bits = '0;
  raw_t in_y_bits = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  key_t out_hilbert_index;

  // Points waiting to go out, and keys predicted for points already taken.
  point_t pending_points[$];
  key_t   expected_keys[$];

  int sender_idle_pct = 22;
  int receiver_stall_pct = 80;
  int points_sent = 0;
  int keys_checked = 0;
  int error_count = 0;
  int directed_count = 0;

  double_pair_hilbert_key dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_x_bits         (in_x_bits),
    .in_y_bits         (in_y_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hilbert_index (out_hilbert_index)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Map a double pattern onto the curve axis: order-preserving flip, then keep the top bits.
  function automatic coord_t axis_coord(input raw_t bits);
    raw_t ordered;
    ordered = bits[RAW_W-1] ? ~bits : {1'b1, bits[RAW_W-2:0]};
    return ordered[RAW_W-1 -: CURVE_ORDER];
  endfunction

  // Hilbert distance of the quantized point, walking levels from the top bit down.
  function automatic key_t hilbert_distance(input raw_t xb, input raw_t yb);
    coord_t qx;
    coord_t qy;
    coord_t held;
    key_t   acc;
    logic   rx;
    logic   ry;
    qx = axis_coord(xb);
    qy = axis_coord(yb);
    acc = '0;
    for (int lvl = CURVE_ORDER - 1; lvl >= 0; lvl--) begin
      rx = qx[lvl];
      ry = qy[lvl];
      // Quadrant digit (3*rx xor ry) weighted by the square of the level size.
      acc = acc + (key_t'({rx, rx ^ ry}) << (2 * lvl));
      if (!ry) begin
        if (rx) begin
          qx = ~qx;
          qy = ~qy;
        end
        held = qx;
        qx = qy;
        qy = held;
      end
    end
    return acc;
  endfunction

  function automatic raw_t special_pattern(input int sel);
    case (sel)
      0:       return POS_ZERO;
      1:       return NEG_ZERO;
      2:       return POS_INF;
      3:       return NEG_INF;
      4:       return POS_QNAN;
      5:       return NEG_QNAN;
      6:       return MAX_NORMAL;
      7:       return MIN_NORMAL;
      8:       return MIN_DENORM;
      9:       return PLUS_ONE;
      10:      return MINUS_ONE;
      11:      return ALL_ONES;
      12:      return POS_NAN_HI;
      13:      return NEG_DENORM;
      14:      return STRIPE_A;
      default: return STRIPE_5;
    endcase
  endfunction

  // A coordinate with a plausible exponent, random sign and random mantissa.
  function automatic raw_t plain_double();
    raw_t r;
    r = {$urandom, $urandom};
    r[62:52] = 11'(983 + $urandom_range(0, 80));
    return r;
  endfunction

  // Step a coordinate by a few units of the lowest kept bit, with fresh low bits.
  function automatic raw_t nudge(input raw_t base);
    raw_t step;
    step = raw_t'($urandom_range(0, 15)) << (RAW_W - CURVE_ORDER);
    return ($urandom_range(0, 1) ? base + step : base - step) ^ raw_t'($urandom);
  endfunction

  // Random point: mostly realistic doubles and close neighbors, plus raw noise and specials.
  function automatic point_t random_point(input point_t last);
    point_t p;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      p.x = plain_double();
      p.y = plain_double();
    end else if (pick < 60) begin
      p.x = nudge(last.x);
      p.y = nudge(last.y);
    end else if (pick < 80) begin
      p.x = {$urandom, $urandom};
      p.y = {$urandom, $urandom};
    end else if (pick < 90) begin
      p.x = special_pattern($urandom_range(0, NUM_SPECIALS - 1));
      p.y = $urandom_range(0, 1) ? special_pattern($urandom_range(0, NUM_SPECIALS - 1))
                                 : plain_double();
    end else begin
      p.x = plain_double();
      p.y = special_pattern($urandom_range(0, NUM_SPECIALS - 1));
    end
    return p;
  endfunction

  // Append a point to the tail of the pending queue.
  task automatic add_point(input raw_t px, input raw_t py);
    point_t p;
    p.x = px;
    p.y = py;
    pending_points.insert(pending_points.size(), p);
  endtask

  // Driver: predict the key of each transfer, then hold or advance the input channel.
  always @(posedge clk) begin : drive_points
    point_t next_point;
    logic   holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        expected_keys.insert(expected_keys.size(), hilbert_distance(in_x_bits, in_y_bits));
        points_sent++;
      end
      // Keep valid and payload steady until the transfer; otherwise offer the next point.
      if (!holding) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_point = pending_points.pop_front();
          in_x_bits <= next_point.x;
          in_y_bits <= next_point.y;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, then pick the next ready.
  always @(posedge clk) begin : check_keys
    key_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected result, expected nothing actual %h", $time, out_hilbert_index);
        error_count++;
      end else begin
        want = expected_keys.pop_front();
        if (out_hilbert_index !== want) begin
          $display("%0t: hilbert_index mismatch, expected %h actual %h",
                   $time, want, out_hilbert_index);
          error_count++;
        end
      end
      keys_checked++;
    end
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Stimulus: reset, directed corners, then random points under three idling mixes.
  initial begin : stimulus
    point_t last;
    int per_phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: all-zero and all-one patterns, signed zeros, infinities, NaNs,
    // extremes of the normal and denormal ranges, and points that land in each quadrant.
    add_point(POS_ZERO,   POS_ZERO);
    add_point(ALL_ONES,   ALL_ONES);
    add_point(POS_ZERO,   NEG_ZERO);
    add_point(NEG_ZERO,   POS_ZERO);
    add_point(NEG_ZERO,   NEG_ZERO);
    add_point(POS_INF,    NEG_INF);
    add_point(NEG_INF,    POS_INF);
    add_point(POS_QNAN,   NEG_QNAN);
    add_point(NEG_QNAN,   POS_NAN_HI);
    add_point(MAX_NORMAL, MIN_NORMAL);
    add_point(MIN_DENORM, NEG_DENORM);
    add_point(PLUS_ONE,   PLUS_ONE);
    add_point(MINUS_ONE,  PLUS_ONE);
    add_point(MINUS_ONE,  MINUS_ONE);
    add_point(PLUS_ONE,   MINUS_ONE);
    add_point(POS_NAN_HI, ALL_ONES);
    add_point(STRIPE_A,   STRIPE_5);
    add_point(STRIPE_5,   STRIPE_A);
    // Low halves fall below the kept bits; only the upper halves matter here.
    add_point(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    add_point(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
    add_point(64'h7FFF_FFFF_0000_0000, 64'h8000_0000_FFFF_FFFF);
    directed_count = pending_points.size();

    per_phase = (TOTAL_POINTS - directed_count) / 3;
    last.x = PLUS_ONE;
    last.y = MINUS_ONE;
    for (int phase = 0; phase < 3; phase++) begin
      // Slow sender with a stalling receiver, then the reverse, then full rate.
      case (phase)
        0: begin
          sender_idle_pct = 22;
          receiver_stall_pct = 80;
        end
        1: begin
          sender_idle_pct = 80;
          receiver_stall_pct = 22;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        last = random_point(last);
        add_point(last.x, last.y);
      end
      wait (pending_points.size() == 0);
    end

    // Drain: wait for the last transfer, every predicted key, then a few quiet cycles.
    wait (!in_valid && expected_keys.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d points (%0d directed corners, rest random) and checked %0d keys",
             points_sent, directed_count, keys_checked);
    $display("Idling mixes covered: slow sender, stalling receiver, and back-to-back");
    if (error_count == 0 && expected_keys.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors, %0d keys still outstanding", error_count, expected_keys.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest legal run takes well under a tenth of this.
  initial begin
    #2_000_000;
    $display("Timeout with %0d points pending and %0d keys outstanding",
             pending_points.size(), expected_keys.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dphk_pkg.sv
hw/rtl/dphk_quant.sv
hw/rtl/dphk_scan.sv
hw/rtl/dphk_digits.sv
hw/rtl/double_pair_hilbert_key.sv
test/double_pair_hilbert_key_tb.sv
